// ===== sv/u8nd_pkg.sv =====
`timescale 1ns / 1ps
// u8nd_pkg: constants, types and decode functions for the utf-8 native digit filter
// depends on nothing; used by utf8_native_digit_to_ascii
package u8nd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned HELD_N   = 3;
    localparam int unsigned MAX_RES  = 4;
    localparam int unsigned NBASE    = 6;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam logic [CP_W-1:0] DIGIT_BASE [NBASE] = '{
        21'h00660, 21'h006F0, 21'h00966, 21'h009E6, 21'h00E50, 21'h017E0
    };

    typedef struct packed {
        logic       hit;
        logic [3:0] val;
    } t_digit;

    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = LEN_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = LEN_THREE;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    // ranges do not overlap, so at most one base hits
    function automatic t_digit native_digit(input logic [CP_W-1:0] cp);
        t_digit          d;
        logic [CP_W-1:0] ofs;
        d = '0;
        for (int i = 0; i < NBASE; i++) begin
            ofs = cp - DIGIT_BASE[i];
            if (cp >= DIGIT_BASE[i] && ofs <= CP_W'(9)) begin
                d.hit = 1'b1;
                d.val = ofs[3:0];
            end
        end
        return d;
    endfunction

endpackage

// ===== sv/utf8_native_digit_to_ascii.sv =====
`timescale 1ns / 1ps
// utf8_native_digit_to_ascii: utf-8 byte stream filter, native decimal digits to ascii
// depends on u8nd_pkg
//
// Usage
//   s_axis carries one utf-8 byte per word, tlast marks the last byte of a string.
//   m_axis carries one output byte per word; tlast marks the last word caused by
//   one input word, tuser[0] marks the final byte of a string and tuser[1] says,
//   on that byte, whether any digit of the string was converted.
//   A complete sequence for a digit in U+0660, 06F0, 0966, 09E6, 0E50 or 17E0 plus
//   0-9 leaves as one ascii digit; every other byte leaves unchanged, in order.
//   Bytes of an open sequence give no word until the sequence completes or the
//   string ends; a sequence cut short by tlast is flushed as-is.
// Timing
//   input register, one level of decode logic, result group register.
//   an accepted word passes the input register, then the result group register, before
//   its output can be taken; one word per cycle on either side while no group drains or stalls.
//   a sequence that passes through unchanged gives up to 4 words, and the next
//   input word that gives output waits while the result group register drains.
// Reset and stall
//   i_rst_n low clears all sequence state and both registers' valid flags.
//   when m_axis_tready is low the result group holds and s_axis_tready drops
//   once the input register holds a word that needs the group.
module utf8_native_digit_to_ascii (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tlast,   // string_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,   // run_last
    output logic [1:0] m_axis_tuser    // string_done, string_changed
);

    localparam int unsigned BW = u8nd_pkg::BYTE_W;

    // input register
    logic          r_in_v;
    logic [BW-1:0] r_in_b;
    logic          r_in_e;

    // sequence state
    logic [BW-1:0] r_held [u8nd_pkg::HELD_N];
    logic [2:0]    r_len;
    logic [1:0]    r_hcnt;
    logic          r_seen;
    logic [2:0]    n_len;
    logic [1:0]    n_hcnt;
    logic          n_seen;

    // result group register
    logic          r_grp_v;
    logic [BW-1:0] r_grp_b [u8nd_pkg::MAX_RES];
    logic [2:0]    r_grp_cnt;
    logic [1:0]    r_grp_idx;
    logic          r_grp_done;
    logic          r_grp_chg;

    logic [BW-1:0] res_b [u8nd_pkg::MAX_RES];
    logic [2:0]    res_n;
    logic          res_chg;
    logic [2:0]    lead_len;
    logic          complete;
    logic [u8nd_pkg::CP_W-1:0] cp;
    u8nd_pkg::t_digit dig;
    logic          grp_last;
    logic          grp_free;
    logic          proc;
    logic          in_acc;

    assign lead_len = u8nd_pkg::lead_length(r_in_b);
    assign complete = (r_len != u8nd_pkg::LEN_NONE)
                    && ((({1'b0, r_hcnt} + 3'd1) >= r_len) || (r_hcnt == 2'd3));

    always_comb begin
        unique case (r_hcnt)
            2'd1:    cp = u8nd_pkg::CP_W'({r_held[0][4:0], r_in_b[5:0]});
            2'd2:    cp = u8nd_pkg::CP_W'({r_held[0][3:0], r_held[1][5:0], r_in_b[5:0]});
            default: cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], r_in_b[5:0]};
        endcase
    end

    assign dig = u8nd_pkg::native_digit(cp);

    always_comb begin
        n_len  = r_len;
        n_hcnt = r_hcnt;
        n_seen = r_seen;
        res_n  = 3'd0;
        res_b[0] = (r_hcnt > 2'd0) ? r_held[0] : r_in_b;
        res_b[1] = (r_hcnt > 2'd1) ? r_held[1] : r_in_b;
        res_b[2] = (r_hcnt > 2'd2) ? r_held[2] : r_in_b;
        res_b[3] = r_in_b;
        if (r_len == u8nd_pkg::LEN_NONE) begin
            res_b[0] = r_in_b;
            if (lead_len == u8nd_pkg::LEN_NONE) begin
                res_n = 3'd1;
            end else begin
                n_len  = lead_len;
                n_hcnt = 2'd1;
                res_n  = r_in_e ? 3'd1 : 3'd0;
            end
        end else if (complete) begin
            n_len  = u8nd_pkg::LEN_NONE;
            n_hcnt = 2'd0;
            if (dig.hit) begin
                res_b[0] = u8nd_pkg::ASCII_ZERO | BW'(dig.val);
                res_n    = 3'd1;
                n_seen   = 1'b1;
            end else begin
                res_n = {1'b0, r_hcnt} + 3'd1;
            end
        end else begin
            n_hcnt = r_hcnt + 2'd1;
            res_n  = r_in_e ? ({1'b0, r_hcnt} + 3'd1) : 3'd0;
        end
        res_chg = n_seen;
        if (r_in_e) begin
            n_len  = u8nd_pkg::LEN_NONE;
            n_hcnt = 2'd0;
            n_seen = 1'b0;
        end
    end

    assign grp_last = ({1'b0, r_grp_idx} == (r_grp_cnt - 3'd1));
    assign grp_free = !r_grp_v || (m_axis_tready && grp_last);
    assign proc     = r_in_v && ((res_n == 3'd0) || grp_free);
    assign s_axis_tready = !r_in_v || proc;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_len     <= u8nd_pkg::LEN_NONE;
            r_hcnt    <= 2'd0;
            r_seen    <= 1'b0;
            r_grp_v   <= 1'b0;
            r_grp_idx <= 2'd0;
        end else begin
            if (in_acc) begin
                r_in_v <= 1'b1;
            end else if (proc) begin
                r_in_v <= 1'b0;
            end
            if (proc) begin
                r_len  <= n_len;
                r_hcnt <= n_hcnt;
                r_seen <= n_seen;
            end
            if (proc && (res_n != 3'd0)) begin
                r_grp_v   <= 1'b1;
                r_grp_idx <= 2'd0;
            end else if (r_grp_v && m_axis_tready) begin
                if (grp_last) begin
                    r_grp_v <= 1'b0;
                end else begin
                    r_grp_idx <= r_grp_idx + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_b <= s_axis_tdata;
            r_in_e <= s_axis_tlast;
        end
        if (proc && (r_len == u8nd_pkg::LEN_NONE)) begin
            r_held[0] <= r_in_b;
        end else if (proc && !complete) begin
            case (r_hcnt)
                2'd1:    r_held[1] <= r_in_b;
                2'd2:    r_held[2] <= r_in_b;
                default: r_held[0] <= r_in_b;
            endcase
        end
        if (proc && (res_n != 3'd0)) begin
            r_grp_b    <= res_b;
            r_grp_cnt  <= res_n;
            r_grp_done <= r_in_e;
            r_grp_chg  <= r_in_e && res_chg;
        end
    end

    assign m_axis_tvalid = r_grp_v;
    assign m_axis_tdata  = r_grp_b[r_grp_idx];
    assign m_axis_tlast  = grp_last;
    assign m_axis_tuser  = {r_grp_chg && grp_last, r_grp_done && grp_last};

endmodule
